// ===== rtl/core/per_task_job_timing_stats_top_macros.svh =====
// assertion macros for the per-task job timing statistics block
// used by the top level; compiled out when SYNTHESIS is defined
`ifndef PER_TASK_JOB_TIMING_STATS_TOP_MACROS_SVH
`define PER_TASK_JOB_TIMING_STATS_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define PJTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define PJTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PJTS_ASSERT_SAME(lbl, ante, cons, msg)

`define PJTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/pjts_pkg.sv =====
// types, constants and helper functions of the per-task job timing statistics block
// no dependencies
package pjts_pkg;

  localparam int TASK_SLOTS = 64;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int METRICS    = 4;
  localparam int COUNT_W    = 24;

  typedef logic signed [31:0] metric_t;
  typedef logic signed [47:0] sum_t;
  typedef metric_t [METRICS-1:0] metric_vec_t;

  localparam metric_t MIN_RESET      = 32'sd1000000;
  localparam metric_t MAX_RESET_LATE = -32'sd1000000;
  localparam logic signed [48:0] SUM_HIGH = 49'sd140737488355327;
  localparam logic signed [48:0] SUM_LOW  = -49'sd140737488355328;
  localparam logic signed [33:0] M32_HIGH = 34'sd2147483647;
  localparam logic signed [33:0] M32_LOW  = -34'sd2147483648;
  localparam logic [COUNT_W-1:0] COUNT_HIGH = '1;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MET_RESPONSE = 2'd0,
    MET_WAITING  = 2'd1,
    MET_LATENCY  = 2'd2,
    MET_LATENESS = 2'd3
  } metric_e;

  typedef struct packed {
    op_e         opcode;
    logic [6:0]  task_number;
    logic [1:0]  metric_select;
    logic [30:0] release_time;
    logic [30:0] first_start_time;
    logic [30:0] completion_time;
    logic [30:0] execution_ticks;
    logic [30:0] deadline_time;
  } in_item_t;

  typedef struct packed {
    logic               status;
    metric_t            min_value;
    metric_t            max_value;
    sum_t               sum_value;
    logic [COUNT_W-1:0] job_count;
  } out_item_t;

  typedef struct packed {
    metric_t min_v;
    metric_t max_v;
    sum_t    sum_v;
  } stat_t;

  typedef struct packed {
    stat_t [METRICS-1:0] stat;
    logic [COUNT_W-1:0]  count;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  function automatic metric_t sat32(logic signed [33:0] v);
    metric_t r;
    priority if (v > M32_HIGH) begin
      r = M32_HIGH[31:0];
    end else if (v < M32_LOW) begin
      r = M32_LOW[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic sum_t sat48(logic signed [48:0] v);
    sum_t r;
    priority if (v > SUM_HIGH) begin
      r = SUM_HIGH[47:0];
    end else if (v < SUM_LOW) begin
      r = SUM_LOW[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic row_t reset_row();
    row_t r;
    r = '0;
    for (int m = 0; m < METRICS; m++) begin
      r.stat[m].min_v = MIN_RESET;
      r.stat[m].max_v = (m == int'(MET_LATENESS)) ? MAX_RESET_LATE : '0;
      r.stat[m].sum_v = '0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pjts_if.sv =====
// valid/ready stream interfaces for record/read items and result items
// depends on pjts_pkg
interface pjts_in_if;
  import pjts_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pjts_out_if;
  import pjts_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/per_task_job_timing_stats_top.sv =====
// an accepted item is held in stage b; its result is registered for output when stage b completes
// throughput: one item per cycle while results are taken; same-task back-to-back records use a forwarded row
// the task row memory is read when an item is accepted and written back when its record leaves stage b
// reset: row valid bits clear at once, unwritten rows read as sentinel values
// depends on pjts_pkg, pjts_if, pjts_ram, pjts_calc, pjts_upd and the macros header
module per_task_job_timing_stats_top (
  input logic        clk_i,
  input logic        rst_ni,
  pjts_in_if.sink    rec_i,
  pjts_out_if.source res_o
);
  import pjts_pkg::*;
  `include "per_task_job_timing_stats_top_macros.svh"

  logic              in_acc;
  logic              task_ok_a;
  logic [SLOT_W-1:0] slot_a;
  metric_vec_t       metric_a;

  logic              b_valid_q;
  op_e               b_op_q;
  logic              b_bad_q;
  logic [SLOT_W-1:0] b_slot_q;
  logic [1:0]        b_sel_q;
  metric_vec_t       b_metric_q;
  logic              fwd_q, fwd_d;
  row_t              fwd_row_q;
  logic              b_done;
  logic              b_wr;

  logic [TASK_SLOTS-1:0] vld_q;
  logic [ROW_W-1:0]      rd_data;
  row_t                  cur_row;
  row_t                  new_row;
  stat_t                 sel_stat;

  logic      out_valid_q;
  out_item_t out_q, out_d;

  assign b_done = b_valid_q && (!out_valid_q || res_o.ready);
  assign b_wr   = b_done && !b_bad_q && (b_op_q == OP_RECORD);

  assign rec_i.ready = !b_valid_q || b_done;
  assign in_acc      = rec_i.valid && rec_i.ready;

  assign task_ok_a = (rec_i.data.task_number != '0) &&
                     (32'(rec_i.data.task_number) <= 32'(TASK_SLOTS));
  assign slot_a    = SLOT_W'(32'(rec_i.data.task_number) - 32'd1);
  assign fwd_d     = in_acc && b_wr && task_ok_a && (slot_a == b_slot_q);

  pjts_calc u_calc (
    .item_i   (rec_i.data),
    .metric_o (metric_a)
  );

  pjts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TASK_SLOTS),
    .AW    (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (b_wr),
    .waddr_i (b_slot_q),
    .wdata_i (new_row),
    .re_i    (in_acc),
    .raddr_i (slot_a),
    .rdata_o (rd_data)
  );

  always_comb begin
    priority if (fwd_q) begin
      cur_row = fwd_row_q;
    end else if (vld_q[b_slot_q]) begin
      cur_row = row_t'(rd_data);
    end else begin
      cur_row = reset_row();
    end
  end

  pjts_upd u_upd (
    .row_i    (cur_row),
    .metric_i (b_metric_q),
    .row_o    (new_row)
  );

  always_comb begin
    sel_stat = cur_row.stat[b_sel_q];
    out_d    = '0;
    priority if (b_bad_q) begin
      out_d.status = 1'b1;
    end else if (b_op_q == OP_READ) begin
      out_d.min_value = sel_stat.min_v;
      out_d.max_value = sel_stat.max_v;
      out_d.sum_value = sel_stat.sum_v;
      out_d.job_count = cur_row.count;
    end else begin
      out_d.status = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      if (in_acc || b_done) begin
        b_valid_q <= in_acc;
        fwd_q     <= fwd_d;
      end
      if (b_done) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (b_wr) begin
        vld_q[b_slot_q] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_op_q     <= rec_i.data.opcode;
      b_bad_q    <= !task_ok_a;
      b_slot_q   <= slot_a;
      b_sel_q    <= rec_i.data.metric_select;
      b_metric_q <= metric_a;
      fwd_row_q  <= new_row;
    end
    if (b_done) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  `PJTS_ASSERT_SAME(a_no_overrun, in_acc && b_valid_q, b_done, "stage overwritten")
  `PJTS_ASSERT_NEXT(a_stall_hold, b_valid_q && !b_done, b_valid_q && $stable(b_slot_q), "stall lost")
  `PJTS_ASSERT_NEXT(a_row_valid, b_wr, vld_q[$past(b_slot_q)], "row valid not set")
  `PJTS_ASSERT_SAME(a_fwd_rec, fwd_q, b_valid_q && !b_bad_q, "forward without item")

endmodule

// ===== rtl/core/pjts_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module pjts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/pjts_calc.sv =====
// forms the four timing metrics of one job record, saturated to 32 bits
// depends on pjts_pkg
module pjts_calc (
  input  pjts_pkg::in_item_t    item_i,
  output pjts_pkg::metric_vec_t metric_o
);
  import pjts_pkg::*;

  logic signed [33:0] rel;
  logic signed [33:0] fst;
  logic signed [33:0] cmp;
  logic signed [33:0] exe;
  logic signed [33:0] ddl;
  logic signed [33:0] resp;

  always_comb begin
    rel  = 34'(item_i.release_time);
    fst  = 34'(item_i.first_start_time);
    cmp  = 34'(item_i.completion_time);
    exe  = 34'(item_i.execution_ticks);
    ddl  = 34'(item_i.deadline_time);
    resp = cmp - rel;
    metric_o[MET_RESPONSE] = sat32(resp);
    metric_o[MET_WAITING]  = sat32(resp - exe);
    metric_o[MET_LATENCY]  = sat32(cmp - fst);
    metric_o[MET_LATENESS] = sat32(cmp - ddl);
  end

endmodule

// ===== rtl/core/pjts_upd.sv =====
// updates min, max and saturating sum of each metric and the job count of one row
// depends on pjts_pkg
module pjts_upd (
  input  pjts_pkg::row_t        row_i,
  input  pjts_pkg::metric_vec_t metric_i,
  output pjts_pkg::row_t        row_o
);
  import pjts_pkg::*;

  always_comb begin
    row_o = row_i;
    for (int m = 0; m < METRICS; m++) begin
      if (metric_i[m] < row_i.stat[m].min_v) begin
        row_o.stat[m].min_v = metric_i[m];
      end
      if (metric_i[m] > row_i.stat[m].max_v) begin
        row_o.stat[m].max_v = metric_i[m];
      end
      row_o.stat[m].sum_v = sat48(49'(row_i.stat[m].sum_v) + 49'(metric_i[m]));
    end
    if (row_i.count != COUNT_HIGH) begin
      row_o.count = row_i.count + COUNT_W'(1);
    end
  end

endmodule
